// ===== design/cpp_pkg.sv =====
// ----------------------------------------------------------------------------
// Closest pair package
// Shared types and constants for the closest pair of points block.
// ----------------------------------------------------------------------------
`default_nettype none

package cpp_pkg;

  localparam int unsigned COORD_W       = 24;
  localparam int unsigned LIMIT_W       = 52;
  localparam int unsigned DIST_W        = 49;
  localparam int unsigned OUT_IDX_W     = 4;
  localparam int unsigned MAX_POINTS_DEF = 16;

  localparam int unsigned APB_ADDR_W = 4;
  localparam int unsigned APB_DATA_W = 64;

  localparam logic [APB_ADDR_W-1:0] ADDR_LIMIT  = 4'h0;
  localparam logic [LIMIT_W-1:0]    LIMIT_RESET = 52'd6553600000000;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
  } point_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x_coord;
    logic signed [COORD_W-1:0] y_coord;
    logic                      last_point;
  } in_t;

  typedef struct packed {
    logic [OUT_IDX_W-1:0] first_index;
    logic [OUT_IDX_W-1:0] second_index;
    logic                 pair_found;
    logic                 overflow;
  } out_t;

endpackage

`default_nettype wire

// ===== design/cpp_cell.sv =====
// ----------------------------------------------------------------------------
// Point cell
// One stage of the point ring: holds a stored point and either takes the
// point of its neighbor or loads a new point.
// ----------------------------------------------------------------------------
`default_nettype none

module cpp_cell
  import cpp_pkg::*;
(
  input  wire    clk_i,
  input  wire    shift_i,
  input  wire    load_i,
  input  point_t nb_pt_i,
  input  point_t ld_pt_i,
  output point_t pt_o
);

  point_t pt_q;

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      pt_q <= ld_pt_i;
    end else if (shift_i) begin
      pt_q <= nb_pt_i;
    end
  end

  assign pt_o = pt_q;

endmodule

`default_nettype wire

// ===== design/cpp_dist.sv =====
// ----------------------------------------------------------------------------
// Squared distance pipeline
// Three stages: absolute differences, squares, sum. Carries a valid bit and
// the index of the stored point alongside the data.
// ----------------------------------------------------------------------------
`default_nettype none

module cpp_dist
  import cpp_pkg::*;
#(
  parameter int unsigned IDX_W = 4
) (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                valid_i,
  input  wire  [IDX_W-1:0]   idx_i,
  input  point_t             a_i,
  input  point_t             b_i,
  output logic               valid_o,
  output logic [IDX_W-1:0]   idx_o,
  output logic [DIST_W-1:0]  dist_o,
  output logic               busy_o
);

  logic signed [COORD_W:0]   dx, dy;
  logic        [COORD_W-1:0] adx, ady;

  logic                      v1_q, v2_q, v3_q;
  logic [IDX_W-1:0]          i1_q, i2_q, i3_q;
  logic [COORD_W-1:0]        adx_q, ady_q;
  logic [2*COORD_W-1:0]      sqx_q, sqy_q;
  logic [DIST_W-1:0]         sum_q;

  always_comb begin
    dx  = (COORD_W+1)'(b_i.x) - (COORD_W+1)'(a_i.x);
    dy  = (COORD_W+1)'(b_i.y) - (COORD_W+1)'(a_i.y);
    // The magnitude of a 25-bit difference of 24-bit values fits in 24 bits.
    adx = dx[COORD_W] ? COORD_W'(-dx) : COORD_W'(dx);
    ady = dy[COORD_W] ? COORD_W'(-dy) : COORD_W'(dy);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    i1_q  <= idx_i;
    adx_q <= adx;
    ady_q <= ady;
    i2_q  <= i1_q;
    sqx_q <= adx_q * adx_q;
    sqy_q <= ady_q * ady_q;
    i3_q  <= i2_q;
    sum_q <= DIST_W'(sqx_q) + DIST_W'(sqy_q);
  end

  assign valid_o = v3_q;
  assign idx_o   = i3_q;
  assign dist_o  = sum_q;
  assign busy_o  = v1_q | v2_q | v3_q;

endmodule

`default_nettype wire

// ===== design/closest_pair_of_points.sv =====
// ----------------------------------------------------------------------------
// Closest pair of points
// Brute force search for the closest pair in a set of up to MAX_POINTS points.
// ----------------------------------------------------------------------------
// Points arrive on the input channel, one per transfer, the final point of a
// set marked by last_point. Each point is compared against every point stored
// earlier in the set; the stored points sit in a ring of cells that rotates
// once per cycle during a sweep, past a shared squared distance pipeline.
// After the final point one result transfer carries the indices of the
// closest pair whose squared distance lies strictly below the programmed
// limit, ties going to the lexicographically first pair.
// Each accepted point is swept through a full rotation of the ring, then the
// pipeline drains and a finish step does the bookkeeping; only then is the
// next point accepted. Points past capacity skip the sweep and the drain.
// The result is loaded into the output register in the finish step of the
// final point, whether or not that point is past capacity.
// The result waits in an output register while the receiver stalls, and new
// points of the next set are still accepted meanwhile; only a second result
// holds the input off until the first one is taken.
// Reset clears the set and restores the limit register to its default.
// ----------------------------------------------------------------------------
`default_nettype none

module closest_pair_of_points
  import cpp_pkg::*;
#(
  parameter int unsigned MAX_POINTS = MAX_POINTS_DEF
) (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    in_valid_i,
  output logic                   in_stall_o,
  input  in_t                    in_data_i,
  output logic                   out_valid_o,
  input  wire                    out_stall_i,
  output out_t                   out_data_o,
  input  wire                    psel,
  input  wire                    penable,
  input  wire                    pwrite,
  input  wire  [APB_ADDR_W-1:0]  paddr,
  input  wire  [APB_DATA_W-1:0]  pwdata,
  output logic [APB_DATA_W-1:0]  prdata,
  output logic                   pready
);

  localparam int unsigned IDX_W = $clog2(MAX_POINTS);
  localparam int unsigned CNT_W = $clog2(MAX_POINTS + 1);
  localparam logic [IDX_W-1:0] LAST_STEP = IDX_W'(MAX_POINTS - 1);
  localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(MAX_POINTS);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_DRAIN,
    ST_FINISH
  } state_e;

  state_e              state_q;
  logic [LIMIT_W-1:0]  limit_q;
  point_t              new_pt_q;
  logic                last_q;
  logic [CNT_W-1:0]    count_q;
  logic [CNT_W-1:0]    n_q;
  logic [IDX_W-1:0]    step_q;
  logic                pair_valid_q;
  logic                overflow_q;
  logic [DIST_W-1:0]   best_sq_q;
  logic [IDX_W-1:0]    best_first_q;
  logic [IDX_W-1:0]    best_second_q;
  logic                out_valid_q;
  out_t                out_q;

  point_t              ring_pt [MAX_POINTS];
  logic                sweep;
  logic                load_step;

  logic                d_valid;
  logic [IDX_W-1:0]    d_idx;
  logic [DIST_W-1:0]   d_dist;
  logic                d_busy;
  logic [LIMIT_W-1:0]  d_ext;
  logic                take;
  logic                cfg_wr;

  logic [IDX_W+OUT_IDX_W-1:0] first_ext, second_ext;

  // Configuration port.
  assign cfg_wr = psel & penable & pwrite & (paddr == ADDR_LIMIT);
  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_LIMIT) ? APB_DATA_W'(limit_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LIMIT_RESET;
    end else if (cfg_wr) begin
      limit_q <= pwdata[LIMIT_W-1:0];
    end
  end

  // Ring of stored points. Cell 0 is the head seen by the distance pipeline;
  // a full rotation brings every point back to its own cell.
  assign sweep     = (state_q == ST_SWEEP);
  assign load_step = sweep && (step_q == LAST_STEP);

  for (genvar k = 0; k < MAX_POINTS; k++) begin : g_cell
    cpp_cell u_cell (
      .clk_i   (clk_i),
      .shift_i (sweep),
      .load_i  (load_step && (n_q[IDX_W-1:0] == IDX_W'(k))),
      .nb_pt_i (ring_pt[(k + 1) % MAX_POINTS]),
      .ld_pt_i (new_pt_q),
      .pt_o    (ring_pt[k])
    );
  end

  cpp_dist #(
    .IDX_W (IDX_W)
  ) u_dist (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (sweep && (CNT_W'(step_q) < n_q)),
    .idx_i   (step_q),
    .a_i     (ring_pt[0]),
    .b_i     (new_pt_q),
    .valid_o (d_valid),
    .idx_o   (d_idx),
    .dist_o  (d_dist),
    .busy_o  (d_busy)
  );

  // Pairs arrive in increasing second index, so a tie only needs the first
  // index compared.
  always_comb begin
    d_ext = LIMIT_W'(d_dist);
    take  = d_valid && (d_ext < limit_q) &&
            (!pair_valid_q || (d_dist < best_sq_q) ||
             ((d_dist == best_sq_q) && (d_idx < best_first_q)));
  end

  assign first_ext  = {{OUT_IDX_W{1'b0}}, best_first_q};
  assign second_ext = {{OUT_IDX_W{1'b0}}, best_second_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      new_pt_q      <= '0;
      last_q        <= 1'b0;
      count_q       <= '0;
      n_q           <= '0;
      step_q        <= '0;
      pair_valid_q  <= 1'b0;
      overflow_q    <= 1'b0;
      best_sq_q     <= '0;
      best_first_q  <= '0;
      best_second_q <= '0;
      out_valid_q   <= 1'b0;
      out_q         <= '0;
    end else begin
      // A result loaded in the same cycle keeps the output register full.
      if (out_valid_q && !out_stall_i && !((state_q == ST_FINISH) && last_q)) begin
        out_valid_q <= 1'b0;
      end

      if (take) begin
        best_sq_q     <= d_dist;
        best_first_q  <= d_idx;
        best_second_q <= n_q[IDX_W-1:0];
        pair_valid_q  <= 1'b1;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            new_pt_q.x <= in_data_i.x_coord;
            new_pt_q.y <= in_data_i.y_coord;
            last_q     <= in_data_i.last_point;
            n_q        <= count_q;
            step_q     <= '0;
            if (count_q == FULL_CNT) begin
              overflow_q <= 1'b1;
              state_q    <= ST_FINISH;
            end else begin
              state_q <= ST_SWEEP;
            end
          end
        end
        ST_SWEEP: begin
          step_q <= step_q + 1'b1;
          if (step_q == LAST_STEP) begin
            count_q <= count_q + 1'b1;
            state_q <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (!d_busy) begin
            state_q <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (!last_q) begin
            state_q <= ST_IDLE;
          end else if (!out_valid_q || !out_stall_i) begin
            out_q.first_index  <= pair_valid_q ? first_ext[OUT_IDX_W-1:0] : '0;
            out_q.second_index <= pair_valid_q ? second_ext[OUT_IDX_W-1:0] : '0;
            out_q.pair_found   <= pair_valid_q;
            out_q.overflow     <= overflow_q;
            out_valid_q        <= 1'b1;
            count_q            <= '0;
            pair_valid_q       <= 1'b0;
            overflow_q         <= 1'b0;
            state_q            <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

// ===== test/closest_pair_of_points_tb.sv =====
// ----------------------------------------------------------------------------
// Closest pair of points testbench
// Sends point sets through the block under several distance limits and
// compares every result transfer with the closest pair that a behavioral
// model computes. Both channels idle at random, and the receiver holds off
// for a long stretch once so that the block has to stall its input.
// ----------------------------------------------------------------------------
module closest_pair_of_points_tb;
  import cpp_pkg::*;

  localparam int unsigned SET_CAP     = MAX_POINTS_DEF;
  localparam int          HOLD_CYCLES = 600;
  localparam int          SETTLE      = 40;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                  in_valid_i  = 1'b0;
  logic                  in_stall_o;
  in_t                   in_data_i   = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  out_t                  out_data_o;
  logic                  psel        = 1'b0;
  logic                  penable     = 1'b0;
  logic                  pwrite      = 1'b0;
  logic [APB_ADDR_W-1:0] paddr       = '0;
  logic [APB_DATA_W-1:0] pwdata      = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  closest_pair_of_points u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  // Points waiting to be sent and closest pairs waiting to come back.
  in_t  point_q[$];
  out_t pair_q[$];

  int idle_pct   = 24;
  int hold_req   = 0;
  int hold_taken = 0;
  int hold_left  = 0;
  int mismatches = 0;

  // Model of the block: the points of the current set and the best pair so far.
  logic signed [COORD_W-1:0] x_seen[SET_CAP];
  logic signed [COORD_W-1:0] y_seen[SET_CAP];
  int unsigned               seen_count = 0;
  logic [LIMIT_W-1:0]        limit_now  = LIMIT_RESET;
  longint unsigned           best_sq    = 0;
  int unsigned               best_a     = 0;
  int unsigned               best_b     = 0;
  bit                        have_pair  = 1'b0;
  bit                        dropped    = 1'b0;

  function automatic void record_point(in_t p);
    longint          dx;
    longint          dy;
    longint unsigned sq;
    out_t            res;
    if (seen_count < SET_CAP) begin
      for (int unsigned k = 0; k < seen_count; k++) begin
        dx = longint'(p.x_coord) - longint'(x_seen[k]);
        dy = longint'(p.y_coord) - longint'(y_seen[k]);
        sq = longint'(dx * dx) + longint'(dy * dy);
        if (sq >= {12'd0, limit_now}) continue;
        // The new pair always has the highest second index seen so far.
        if (!have_pair || sq < best_sq || (sq == best_sq && k < best_a)) begin
          best_sq   = sq;
          best_a    = k;
          best_b    = seen_count;
          have_pair = 1'b1;
        end
      end
      x_seen[seen_count] = p.x_coord;
      y_seen[seen_count] = p.y_coord;
      seen_count++;
    end else begin
      dropped = 1'b1;
    end
    if (p.last_point) begin
      res.first_index  = have_pair ? best_a[OUT_IDX_W-1:0] : '0;
      res.second_index = have_pair ? best_b[OUT_IDX_W-1:0] : '0;
      res.pair_found   = have_pair;
      res.overflow     = dropped;
      pair_q.push_back(res);
      seen_count = 0;
      have_pair  = 1'b0;
      dropped    = 1'b0;
    end
  endfunction

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // Point sender: a transfer completes at an edge with valid high and stall low.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) record_point(in_data_i);
      if (!in_valid_i || !in_stall_o) begin
        if (point_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
          in_valid_i <= 1'b1;
          in_data_i  <= point_q.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Result receiver, with an occasional long hold-off on request.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (hold_req != hold_taken) begin
        hold_taken = hold_req;
        hold_left  = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(99) < idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pair_q.size() == 0) begin
        $error("result transfer with no set pending: %p", out_data_o);
        mismatches++;
      end else begin
        want = pair_q.pop_front();
        if (out_data_o.first_index !== want.first_index) begin
          $error("first_index: expected %0d, got %0d", want.first_index,
                 out_data_o.first_index);
          mismatches++;
        end
        if (out_data_o.second_index !== want.second_index) begin
          $error("second_index: expected %0d, got %0d", want.second_index,
                 out_data_o.second_index);
          mismatches++;
        end
        if (out_data_o.pair_found !== want.pair_found) begin
          $error("pair_found: expected %0d, got %0d", want.pair_found,
                 out_data_o.pair_found);
          mismatches++;
        end
        if (out_data_o.overflow !== want.overflow) begin
          $error("overflow: expected %0d, got %0d", want.overflow,
                 out_data_o.overflow);
          mismatches++;
        end
      end
    end
  end

  task automatic add_point(int x, int y, bit last);
    in_t p;
    p.x_coord    = COORD_W'(x);
    p.y_coord    = COORD_W'(y);
    p.last_point = last;
    point_q.push_back(p);
  endtask

  function automatic int wide_coord();
    case ($urandom_range(9))
      0:       return -8388608;
      1:       return 8388607;
      default: return int'($urandom) >>> 8;
    endcase
  endfunction

  // Sets come as scattered points, tight clusters, or a coarse grid where
  // duplicates and equal distances are common.
  task automatic add_set(int n, int style);
    int bx;
    int by;
    int span;
    int step;
    int x;
    int y;
    bx   = int'($urandom) >>> 8;
    by   = int'($urandom) >>> 8;
    span = 1 << $urandom_range(2, 22);
    step = $urandom_range(1, 3000);
    for (int k = 0; k < n; k++) begin
      case (style)
        0: begin
          x = wide_coord();
          y = wide_coord();
        end
        1: begin
          x = bx + int'($urandom_range(0, span)) - span / 2;
          y = by + int'($urandom_range(0, span)) - span / 2;
        end
        default: begin
          x = bx + step * int'($urandom_range(0, 3));
          y = by + step * int'($urandom_range(0, 3));
        end
      endcase
      add_point(x, y, k == n - 1);
    end
  endtask

  function automatic int set_size();
    int r;
    r = $urandom_range(99);
    if (r < 5) return 1;
    if (r < 12) return $urandom_range(SET_CAP + 1, SET_CAP + 4);
    return $urandom_range(2, SET_CAP);
  endfunction

  task automatic random_sets(int items);
    int sent;
    int n;
    sent = 0;
    while (sent < items) begin
      n = set_size();
      add_set(n, $urandom_range(2));
      sent += n;
    end
  endtask

  task automatic write_limit(logic [LIMIT_W-1:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_LIMIT;
    pwdata  <= APB_DATA_W'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    limit_now = value;
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata[LIMIT_W-1:0] !== value) begin
      $error("squared_distance_limit: expected %0d, got %0d", value,
             prdata[LIMIT_W-1:0]);
      mismatches++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Waits until every queued point went out and every result came back.
  task automatic drain();
    do @(posedge clk_i);
    while (point_q.size() != 0 || in_valid_i || pair_q.size() != 0);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Default limit straight out of reset.
    add_point(0, 0, 1'b1);
    add_point(-8388608, 8388607, 1'b0);
    add_point(-8388608, 8388607, 1'b1);
    add_point(-8388608, -8388608, 1'b0);
    add_point(8388607, 8388607, 1'b1);
    // A pair exactly at the limit does not count; one just inside does.
    add_point(0, 0, 1'b0);
    add_point(2560000, 0, 1'b0);
    add_point(0, 2559999, 1'b1);
    // Evenly spaced points, all neighbors tied, one point more than fits.
    for (int k = 0; k <= SET_CAP; k++) add_point(100 * k, 0, k == SET_CAP);
    drain();

    write_limit({LIMIT_W{1'b1}});
    add_point(-8388608, -8388608, 1'b0);
    add_point(8388607, 8388607, 1'b1);
    random_sets(300);
    drain();

    write_limit('0);
    random_sets(150);
    drain();

    // Only coincident points count under a limit of one.
    write_limit(LIMIT_W'(1));
    random_sets(200);
    drain();

    write_limit(LIMIT_W'({$urandom, $urandom} >> $urandom_range(12, 40)));
    idle_pct = 0;
    random_sets(300);
    drain();
    idle_pct = 24;

    // Short sets while the receiver holds off: a result waits in the block and its input stalls.
    write_limit(LIMIT_RESET);
    for (int k = 0; k < 80; k++) add_set($urandom_range(2, 3), $urandom_range(1, 2));
    hold_req++;
    drain();

    random_sets(600);
    drain();

    if (mismatches == 0) begin
      $display("closest_pair_of_points verification clean");
    end else begin
      $display("closest_pair_of_points verification failed");
    end
    $finish;
  end

  initial begin
    #(12 * 600000);
    $display("closest_pair_of_points verification failed");
    $finish;
  end

endmodule
